@@ src/htg_pkg.sv @@
// Shared constants, types, microprogram and sine table of the harmonic tone generator.
`default_nettype none

package htg_pkg;

  localparam int unsigned SINE_DEPTH = 1024;
  localparam int unsigned SINE_AW    = $clog2(SINE_DEPTH);
  localparam int unsigned CNT_W      = 20;
  localparam int unsigned PHASE_W    = 32;
  localparam int unsigned STEP_W     = 31;
  localparam int unsigned ENV_W      = 25;
  localparam int unsigned FSTEP_W    = 24;
  localparam int unsigned VOL_W      = 16;
  localparam int unsigned SMP_W      = 16;
  localparam int unsigned PADDR_W    = 4;
  localparam int unsigned PDATA_W    = 32;
  localparam int unsigned PC_W       = 4;

  localparam logic [ENV_W-1:0]   ENV_ONE         = ENV_W'(1) << 24;
  localparam logic [CNT_W-1:0]   NOTE_LENGTH_RST = CNT_W'(35280);
  localparam logic [CNT_W-1:0]   FADE_START_RST  = CNT_W'(24696);
  localparam logic [FSTEP_W-1:0] FADE_STEP_RST   = FSTEP_W'(1585);
  localparam logic [VOL_W-1:0]   VOLUME_RST      = VOL_W'(32768);

  localparam logic [15:0] HARM_W0 = 16'd39322;
  localparam logic [15:0] HARM_W1 = 16'd13107;
  localparam logic [15:0] HARM_W2 = 16'd6554;
  localparam logic [15:0] HARM_W3 = 16'd3277;

  localparam logic [PC_W-1:0] PC_EMIT = PC_W'(13);

  typedef enum logic [1:0] {
    REG_NOTE_LENGTH,
    REG_FADE_START,
    REG_FADE_STEP,
    REG_VOLUME
  } reg_idx_e;

  typedef enum logic [1:0] {HP_HOLD, HP_LOAD, HP_ADD} hp_op_e;
  typedef enum logic [2:0] {MUL_NONE, MUL_HARM, MUL_VOL, MUL_ENV_LO, MUL_ENV_HI} mul_op_e;
  typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD} acc_op_e;
  typedef enum logic [1:0] {MAG_HOLD, MAG_ABS, MAG_PROD} mag_op_e;
  typedef enum logic [1:0] {JMP_NEXT, JMP_IF_OFF, JMP_EMIT} jmp_e;

  typedef struct packed {
    hp_op_e     hp_op;
    logic       rom_rd;
    mul_op_e    mul_op;
    logic [1:0] harm;
    acc_op_e    acc_op;
    mag_op_e    mag_op;
    logic       lo_ld;
    logic       tot_ld;
    jmp_e       jmp;
  } ucode_t;

  function automatic ucode_t ucode_rom(logic [PC_W-1:0] pc);
    ucode_t uc;
    uc.hp_op  = HP_HOLD;
    uc.rom_rd = 1'b0;
    uc.mul_op = MUL_NONE;
    uc.harm   = 2'd0;
    uc.acc_op = ACC_HOLD;
    uc.mag_op = MAG_HOLD;
    uc.lo_ld  = 1'b0;
    uc.tot_ld = 1'b0;
    uc.jmp    = JMP_NEXT;
    unique case (pc)
      PC_W'(0): begin
        uc.hp_op = HP_LOAD;
        uc.jmp   = JMP_IF_OFF;
      end
      PC_W'(1): begin
        uc.rom_rd = 1'b1;
        uc.hp_op  = HP_ADD;
      end
      PC_W'(2): begin
        uc.mul_op = MUL_HARM;
        uc.harm   = 2'd0;
        uc.rom_rd = 1'b1;
        uc.hp_op  = HP_ADD;
      end
      PC_W'(3): begin
        uc.acc_op = ACC_LOAD;
        uc.mul_op = MUL_HARM;
        uc.harm   = 2'd1;
        uc.rom_rd = 1'b1;
        uc.hp_op  = HP_ADD;
      end
      PC_W'(4): begin
        uc.acc_op = ACC_ADD;
        uc.mul_op = MUL_HARM;
        uc.harm   = 2'd2;
        uc.rom_rd = 1'b1;
      end
      PC_W'(5): begin
        uc.acc_op = ACC_ADD;
        uc.mul_op = MUL_HARM;
        uc.harm   = 2'd3;
      end
      PC_W'(6): begin
        uc.acc_op = ACC_ADD;
      end
      PC_W'(7): begin
        uc.mag_op = MAG_ABS;
      end
      PC_W'(8): begin
        uc.mul_op = MUL_VOL;
      end
      PC_W'(9): begin
        uc.mag_op = MAG_PROD;
      end
      PC_W'(10): begin
        uc.mul_op = MUL_ENV_LO;
      end
      PC_W'(11): begin
        uc.mul_op = MUL_ENV_HI;
        uc.lo_ld  = 1'b1;
      end
      PC_W'(12): begin
        uc.tot_ld = 1'b1;
      end
      PC_EMIT: begin
        uc.jmp = JMP_EMIT;
      end
      default: begin
        uc.jmp = JMP_EMIT;
      end
    endcase
    return uc;
  endfunction

  function automatic logic [15:0] harm_weight(logic [1:0] h);
    logic [15:0] w;
    unique case (h)
      2'd0: w = HARM_W0;
      2'd1: w = HARM_W1;
      2'd2: w = HARM_W2;
      2'd3: w = HARM_W3;
      default: w = HARM_W0;
    endcase
    return w;
  endfunction

  localparam longint Q30 = 64'sd1073741824;
  localparam longint Q30_HALF = Q30 / 2;
  localparam longint POLY_C [6] = '{
    64'sd1686629713, -64'sd693598668, 64'sd85569306,
    -64'sd5026995, 64'sd172272, -64'sd3864
  };

  // scale down by 2^30, rounding toward zero
  function automatic longint q30_trunc(longint x);
    return (x < 0) ? -((-x) >>> 30) : (x >>> 30);
  endfunction

  function automatic longint qmul(longint a, longint b);
    return q30_trunc(a * b);
  endfunction

  function automatic longint quarter_sin(longint t);
    longint u;
    longint p;
    u = qmul(t, t);
    p = POLY_C[5];
    for (int k = 4; k >= 0; k--) begin
      p = POLY_C[k] + qmul(u, p);
    end
    return qmul(t, p);
  endfunction

  typedef logic signed [SMP_W-1:0] sine_rom_t [SINE_DEPTH];

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    longint ph;
    longint q;
    longint r;
    longint t;
    longint s;
    longint v;
    for (int i = 0; i < int'(SINE_DEPTH); i++) begin
      ph = longint'(i) <<< (PHASE_W - SINE_AW);
      q  = (ph >>> 30) & 64'sd3;
      r  = ph & 64'sh3FFF_FFFF;
      t  = q[0] ? (Q30 - r) : r;
      s  = quarter_sin(t);
      v  = q30_trunc(s * 64'sd32767 + Q30_HALF);
      if (v < 0) v = 0;
      if (v > 64'sd32767) v = 64'sd32767;
      rom[i] = (q >= 64'sd2) ? -SMP_W'(v) : SMP_W'(v);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

`default_nettype wire

@@ src/harmonic_tone_generator.sv @@
// Top level: microcoded additive sine synthesizer with linear fade envelope.
// A request is taken while the sequencer is idle; the emit step registers its result.
// Sounding requests run every step, idle ticks skip to emit; one shared 33x26 multiplier
// and the registered sine ROM are stepped by a 14-word control program.
// Reset restores the default registers, stops the note, clears phase and count,
// and sets the envelope to one.
`default_nettype none

module harmonic_tone_generator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                func_i,
  input  logic [htg_pkg::STEP_W-1:0]          phase_step_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [htg_pkg::SMP_W-1:0]    sample_o,
  output logic                                active_o,
  output logic                                last_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [htg_pkg::PADDR_W-1:0]         paddr,
  input  logic [htg_pkg::PDATA_W-1:0]         pwdata,
  output logic [htg_pkg::PDATA_W-1:0]         prdata,
  output logic                                pready
);

  logic [htg_pkg::CNT_W-1:0]   note_length_q;
  logic [htg_pkg::CNT_W-1:0]   fade_start_q;
  logic [htg_pkg::FSTEP_W-1:0] fade_step_q;
  logic [htg_pkg::VOL_W-1:0]   volume_q;
  htg_pkg::reg_idx_e           reg_idx;
  logic                        cfg_wr;

  logic                        busy_q, busy_d;
  logic [htg_pkg::PC_W-1:0]    pc_q, pc_d;
  htg_pkg::ucode_t             uc;
  logic                        accept;
  logic                        out_free;
  logic                        emit;

  logic [htg_pkg::PHASE_W-1:0] phase_q, phase_d;
  logic [htg_pkg::STEP_W-1:0]  step_q, step_d;
  logic [htg_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic [htg_pkg::CNT_W-1:0]   cnt_inc;
  logic [htg_pkg::ENV_W-1:0]   env_q, env_d;
  logic                        note_on_q, note_on_d;
  logic                        fin;

  logic [htg_pkg::PHASE_W-1:0] hp_q;
  logic signed [htg_pkg::SMP_W-1:0] rom_q;
  logic signed [32:0]          mul_a;
  logic signed [25:0]          mul_b;
  logic signed [58:0]          mul_p;
  logic signed [58:0]          prod_q;
  logic signed [33:0]          acc_q;
  logic [46:0]                 mag_q;
  logic                        neg_q;
  logic [24:0]                 lo_q;
  logic [48:0]                 tot_q;
  logic [14:0]                 mag15;
  logic signed [htg_pkg::SMP_W-1:0] smp;

  logic                        out_valid_q;
  logic signed [htg_pkg::SMP_W-1:0] sample_q;
  logic                        active_q;
  logic                        last_q;

  // configuration port
  assign pready  = 1'b1;
  assign reg_idx = htg_pkg::reg_idx_e'(paddr[htg_pkg::PADDR_W-1:2]);
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      note_length_q <= htg_pkg::NOTE_LENGTH_RST;
      fade_start_q  <= htg_pkg::FADE_START_RST;
      fade_step_q   <= htg_pkg::FADE_STEP_RST;
      volume_q      <= htg_pkg::VOLUME_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        htg_pkg::REG_NOTE_LENGTH: note_length_q <= pwdata[htg_pkg::CNT_W-1:0];
        htg_pkg::REG_FADE_START:  fade_start_q  <= pwdata[htg_pkg::CNT_W-1:0];
        htg_pkg::REG_FADE_STEP:   fade_step_q   <= pwdata[htg_pkg::FSTEP_W-1:0];
        htg_pkg::REG_VOLUME:      volume_q      <= pwdata[htg_pkg::VOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      htg_pkg::REG_NOTE_LENGTH: prdata = htg_pkg::PDATA_W'(note_length_q);
      htg_pkg::REG_FADE_START:  prdata = htg_pkg::PDATA_W'(fade_start_q);
      htg_pkg::REG_FADE_STEP:   prdata = htg_pkg::PDATA_W'(fade_step_q);
      htg_pkg::REG_VOLUME:      prdata = htg_pkg::PDATA_W'(volume_q);
      default:                  prdata = '0;
    endcase
  end

  // sequencer
  assign uc         = htg_pkg::ucode_rom(pc_q);
  assign in_ready_o = ~busy_q;
  assign accept     = in_valid_i & in_ready_o;
  assign out_free   = ~out_valid_q | out_ready_i;
  assign emit       = busy_q & (uc.jmp == htg_pkg::JMP_EMIT) & out_free;

  always_comb begin
    pc_d   = pc_q;
    busy_d = busy_q;
    if (accept) begin
      busy_d = 1'b1;
      pc_d   = '0;
    end else if (busy_q) begin
      unique case (uc.jmp)
        htg_pkg::JMP_NEXT:   pc_d = pc_q + 1'b1;
        htg_pkg::JMP_IF_OFF: pc_d = note_on_q ? pc_q + 1'b1 : htg_pkg::PC_EMIT;
        htg_pkg::JMP_EMIT: begin
          if (out_free) begin
            busy_d = 1'b0;
            pc_d   = '0;
          end
        end
        default: pc_d = pc_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= '0;
    end else begin
      busy_q <= busy_d;
      pc_q   <= pc_d;
    end
  end

  // note state
  assign cnt_inc = cnt_q + 1'b1;
  assign fin     = (cnt_inc == note_length_q);

  always_comb begin
    phase_d   = phase_q;
    step_d    = step_q;
    cnt_d     = cnt_q;
    env_d     = env_q;
    note_on_d = note_on_q;
    if (accept && func_i) begin
      step_d    = phase_step_i;
      phase_d   = '0;
      cnt_d     = '0;
      env_d     = htg_pkg::ENV_ONE;
      note_on_d = 1'b1;
    end else if (emit && note_on_q) begin
      phase_d = phase_q + {1'b0, step_q};
      if (cnt_q >= fade_start_q) begin
        env_d = (env_q > {1'b0, fade_step_q}) ? env_q - {1'b0, fade_step_q} : '0;
      end
      cnt_d = cnt_inc;
      if (fin) begin
        note_on_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= '0;
      step_q    <= '0;
      cnt_q     <= '0;
      env_q     <= htg_pkg::ENV_ONE;
      note_on_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      step_q    <= step_d;
      cnt_q     <= cnt_d;
      env_q     <= env_d;
      note_on_q <= note_on_d;
    end
  end

  // datapath
  always_comb begin
    case (uc.mul_op)
      htg_pkg::MUL_HARM: begin
        mul_a = {{17{rom_q[htg_pkg::SMP_W-1]}}, rom_q};
        mul_b = {10'b0, htg_pkg::harm_weight(uc.harm)};
      end
      htg_pkg::MUL_VOL: begin
        mul_a = {1'b0, mag_q[31:0]};
        mul_b = {10'b0, volume_q};
      end
      htg_pkg::MUL_ENV_LO: begin
        mul_a = {9'b0, mag_q[23:0]};
        mul_b = {1'b0, env_q};
      end
      htg_pkg::MUL_ENV_HI: begin
        mul_a = {10'b0, mag_q[46:24]};
        mul_b = {1'b0, env_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    if (busy_q && uc.rom_rd) begin
      rom_q <= htg_pkg::SINE_ROM[hp_q[htg_pkg::PHASE_W-1 -: htg_pkg::SINE_AW]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      case (uc.hp_op)
        htg_pkg::HP_LOAD: hp_q <= phase_q;
        htg_pkg::HP_ADD:  hp_q <= hp_q + phase_q;
        default:          hp_q <= hp_q;
      endcase
      if (uc.mul_op != htg_pkg::MUL_NONE) begin
        prod_q <= mul_p;
      end
      case (uc.acc_op)
        htg_pkg::ACC_LOAD: acc_q <= $signed(prod_q[33:0]);
        htg_pkg::ACC_ADD:  acc_q <= acc_q + $signed(prod_q[33:0]);
        default:           acc_q <= acc_q;
      endcase
      case (uc.mag_op)
        htg_pkg::MAG_ABS: begin
          mag_q <= {13'b0, (acc_q[33] ? -acc_q : acc_q)};
          neg_q <= acc_q[33];
        end
        htg_pkg::MAG_PROD: mag_q <= prod_q[46:0];
        default:           mag_q <= mag_q;
      endcase
      if (uc.lo_ld) begin
        lo_q <= prod_q[48:24];
      end
      if (uc.tot_ld) begin
        tot_q <= {1'b0, prod_q[47:0]} + {24'b0, lo_q};
      end
    end
  end

  assign mag15 = (|tot_q[48:47]) ? 15'h7FFF : tot_q[46:32];
  assign smp   = neg_q ? -$signed({1'b0, mag15}) : $signed({1'b0, mag15});

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      sample_q <= note_on_q ? smp : '0;
      active_q <= note_on_q;
      last_q   <= note_on_q & fin;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;
  assign active_o    = active_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

@@ tb/harmonic_tone_generator_tb.sv @@
// Self-checking testbench of the harmonic tone generator against an in-bench tone predictor.
`default_nettype none

module harmonic_tone_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD = 4;
  localparam int LUT_DEPTH = htg_pkg::SINE_DEPTH;
  localparam longint ONE_Q30 = 64'sd1073741824;
  localparam longint SIN_COEF [6] = '{
    64'sd1686629713, -64'sd693598668, 64'sd85569306,
    -64'sd5026995, 64'sd172272, -64'sd3864
  };
  localparam longint PARTIAL_GAIN [4] = '{64'sd39322, 64'sd13107, 64'sd6554, 64'sd3277};
  localparam logic [24:0] UNITY_GAIN = 25'h100_0000;
  localparam int unsigned LIMIT_CYCLES = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 16;

  typedef struct packed {
    logic [15:0] sample;
    logic        active;
    logic        last;
  } tone_out_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        func_i = 1'b0;
  logic [30:0] phase_step_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic signed [15:0] sample_o;
  logic        active_o;
  logic        last_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [htg_pkg::PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic signed [15:0] sine_lut [LUT_DEPTH];
  logic [19:0] cfg_note_len;
  logic [19:0] cfg_fade_start;
  logic [23:0] cfg_fade_step;
  logic [15:0] cfg_volume;
  logic [31:0] tone_phase;
  logic [30:0] tone_step;
  logic [19:0] tone_count;
  logic [24:0] tone_env;
  logic        tone_on;

  tone_out_t   expected_q [$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;

  harmonic_tone_generator dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .phase_step_i (phase_step_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sample_o     (sample_o),
    .active_o     (active_o),
    .last_o       (last_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic longint fix_mul(longint a, longint b);
    return (a * b) / ONE_Q30;
  endfunction

  function automatic longint sin_quarter(longint x);
    longint x2;
    longint acc;
    x2 = fix_mul(x, x);
    acc = SIN_COEF[5];
    for (int k = 4; k >= 0; k--) begin
      acc = SIN_COEF[k] + fix_mul(x2, acc);
    end
    return fix_mul(x, acc);
  endfunction

  function automatic void fill_sine_lut();
    longint frac;
    longint quadrant;
    longint offset;
    longint arg;
    longint amp;
    for (int i = 0; i < LUT_DEPTH; i++) begin
      frac = (longint'(i) << 32) / LUT_DEPTH;
      quadrant = frac >> 30;
      offset = frac & (ONE_Q30 - 1);
      arg = quadrant[0] ? ONE_Q30 - offset : offset;
      amp = (sin_quarter(arg) * 64'sd32767 + ONE_Q30 / 2) / ONE_Q30;
      if (amp < 0) amp = 0;
      if (amp > 32767) amp = 32767;
      sine_lut[i] = (quadrant >= 2) ? -16'(amp) : 16'(amp);
    end
  endfunction

  function automatic logic signed [15:0] lut_read(logic [31:0] ph);
    logic [63:0] idx;
    idx = (64'(ph) * 64'(LUT_DEPTH)) >> 32;
    if (idx >= 64'(LUT_DEPTH)) idx = '0;
    return sine_lut[idx];
  endfunction

  function automatic logic [15:0] tone_sample();
    longint      mix;
    logic [31:0] ph_h;
    logic [63:0] mag;
    logic [63:0] hi;
    logic [63:0] lo;
    logic        neg;
    mix = 0;
    for (int h = 1; h <= 4; h++) begin
      ph_h = tone_phase * 32'(h);
      mix += PARTIAL_GAIN[h-1] * longint'(lut_read(ph_h));
    end
    neg = mix < 0;
    mag = neg ? 64'(-mix) : 64'(mix);
    mag = mag * 64'(cfg_volume);
    hi = mag * 64'(tone_env >> 12);
    lo = mag * 64'(tone_env & 25'hFFF);
    mag = (hi + (lo >> 12)) >> 44;
    if (mag > 64'd32767) mag = 64'd32767;
    return neg ? -16'(mag) : 16'(mag);
  endfunction

  function automatic tone_out_t advance_tone(logic f, logic [30:0] ps);
    tone_out_t res;
    logic      fin;
    res = '0;
    if (f) begin
      tone_step = ps;
      tone_phase = '0;
      tone_count = '0;
      tone_env = UNITY_GAIN;
      tone_on = 1'b1;
    end
    if (tone_on) begin
      fin = (tone_count + 20'd1) == cfg_note_len;
      res.sample = tone_sample();
      res.active = 1'b1;
      res.last = fin;
      tone_phase = tone_phase + 32'(tone_step);
      if (tone_count >= cfg_fade_start) begin
        tone_env = (tone_env > 25'(cfg_fade_step)) ? tone_env - 25'(cfg_fade_step) : '0;
      end
      tone_count = tone_count + 20'd1;
      if (fin) tone_on = 1'b0;
    end
    return res;
  endfunction

  function automatic logic [31:0] reg_field_mask(htg_pkg::reg_idx_e r);
    case (r)
      htg_pkg::REG_NOTE_LENGTH: return 32'h000F_FFFF;
      htg_pkg::REG_FADE_START:  return 32'h000F_FFFF;
      htg_pkg::REG_FADE_STEP:   return 32'h00FF_FFFF;
      default:                  return 32'h0000_FFFF;
    endcase
  endfunction

  function automatic logic [31:0] reg_value(htg_pkg::reg_idx_e r);
    case (r)
      htg_pkg::REG_NOTE_LENGTH: return 32'(cfg_note_len);
      htg_pkg::REG_FADE_START:  return 32'(cfg_fade_start);
      htg_pkg::REG_FADE_STEP:   return 32'(cfg_fade_step);
      default:                  return 32'(cfg_volume);
    endcase
  endfunction

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("%0t: timeout, %0d samples still expected", $time, expected_q.size());
      $display("harmonic_tone_generator_tb: FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin : check_samples
    tone_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected sample %0d active %0b last %0b", $time, sample_o,
                 active_o, last_o);
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        if (sample_o !== want.sample) begin
          $display("%0t: sample expected %0d, got %0d", $time, $signed(want.sample),
                   sample_o);
          mismatches++;
        end
        if (active_o !== want.active) begin
          $display("%0t: active expected %0b, got %0b", $time, want.active, active_o);
          mismatches++;
        end
        if (last_o !== want.last) begin
          $display("%0t: last expected %0b, got %0b", $time, want.last, last_o);
          mismatches++;
        end
      end
    end
  end

  task automatic send_request(input logic f, input logic [30:0] ps);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= f;
    phase_step_i <= ps;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_q.push_back(advance_tone(f, ps));
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_xfer(input logic wr, input htg_pkg::reg_idx_e r, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= htg_pkg::PADDR_W'({r, 2'b00});
    pwdata <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_reg(input htg_pkg::reg_idx_e r);
    logic [31:0] rd;
    logic [31:0] want;
    want = reg_value(r);
    apb_xfer(1'b0, r, $urandom(), rd);
    if ((rd & reg_field_mask(r)) !== want) begin
      $display("%0t: register %s expected %0d, got %0d", $time, r.name(), want,
               rd & reg_field_mask(r));
      mismatches++;
    end
  endtask

  task automatic set_reg(input htg_pkg::reg_idx_e r, input logic [31:0] field);
    logic [31:0] wdata;
    logic [31:0] rd;
    wdata = (field & reg_field_mask(r)) | ($urandom() & ~reg_field_mask(r));
    apb_xfer(1'b1, r, wdata, rd);
    case (r)
      htg_pkg::REG_NOTE_LENGTH: cfg_note_len = wdata[19:0];
      htg_pkg::REG_FADE_START:  cfg_fade_start = wdata[19:0];
      htg_pkg::REG_FADE_STEP:   cfg_fade_step = wdata[23:0];
      default:                  cfg_volume = wdata[15:0];
    endcase
    check_reg(r);
  endtask

  task automatic set_voice(input logic [19:0] len, input logic [19:0] fstart,
                           input logic [23:0] fstep, input logic [15:0] vol);
    set_reg(htg_pkg::REG_NOTE_LENGTH, 32'(len));
    set_reg(htg_pkg::REG_FADE_START, 32'(fstart));
    set_reg(htg_pkg::REG_FADE_STEP, 32'(fstep));
    set_reg(htg_pkg::REG_VOLUME, 32'(vol));
  endtask

  task automatic test_idle_ticks();
    send_request(1'b0, 31'h7FFF_FFFF);
    send_request(1'b0, 31'h0);
    wait_idle();
  endtask

  task automatic test_default_note();
    check_reg(htg_pkg::REG_NOTE_LENGTH);
    check_reg(htg_pkg::REG_FADE_START);
    check_reg(htg_pkg::REG_FADE_STEP);
    check_reg(htg_pkg::REG_VOLUME);
    send_request(1'b1, 31'h7FFF_FFFF);
    send_request(1'b0, 31'h0);
    send_request(1'b0, 31'h2AAA_AAAA);
    send_request(1'b1, 31'h0123_4567);
    send_request(1'b0, 31'h5555_5555);
    wait_idle();
  endtask

  task automatic test_gain_extremes();
    set_voice(20'd3, 20'd0, 24'hFF_FFFF, 16'hFFFF);
    send_request(1'b1, 31'h0AAA_AAAB);
    send_request(1'b0, 31'h0);
    send_request(1'b0, 31'h0);
    send_request(1'b0, 31'h0);
    wait_idle();
    set_voice(20'd1, 20'd0, 24'h0, 16'h0);
    send_request(1'b1, 31'h1234_5678);
    wait_idle();
    set_reg(htg_pkg::REG_VOLUME, 32'hFFFF);
    send_request(1'b1, 31'h1000_0000);
    send_request(1'b0, 31'h1000_0000);
    wait_idle();
  endtask

  task automatic test_wrapping_length();
    set_voice(20'd0, 20'hF_FFFF, 24'd1585, 16'd40000);
    send_request(1'b1, 31'h0333_3333);
    send_request(1'b0, 31'h0);
    send_request(1'b0, 31'h0);
    send_request(1'b0, 31'h0);
    wait_idle();
    set_reg(htg_pkg::REG_NOTE_LENGTH, 32'd5);
    send_request(1'b0, 31'h0);
    send_request(1'b0, 31'h0);
    wait_idle();
    set_voice(20'hF_FFFF, 20'd2, 24'h08_0000, 16'd50000);
    send_request(1'b1, 31'h0700_0000);
    send_request(1'b0, 31'h0);
    send_request(1'b0, 31'h0);
    wait_idle();
  endtask

  task automatic randomize_voice();
    logic [19:0] len;
    logic [19:0] fstart;
    logic [23:0] fstep;
    logic [15:0] vol;
    case ($urandom_range(19))
      0: len = 20'd1;
      1: len = 20'hF_FFFF;
      2: len = 20'd0;
      default: len = 20'($urandom_range(2, 48));
    endcase
    case ($urandom_range(9))
      0: fstart = 20'd0;
      1: fstart = 20'hF_FFFF;
      default: fstart = 20'($urandom_range(0, 52));
    endcase
    case ($urandom_range(9))
      0: fstep = 24'd0;
      1: fstep = 24'hFF_FFFF;
      2: fstep = 24'($urandom());
      default: fstep = 24'($urandom_range(0, 1 << 21));
    endcase
    case ($urandom_range(9))
      0: vol = 16'd0;
      1: vol = 16'hFFFF;
      default: vol = 16'($urandom());
    endcase
    set_voice(len, fstart, fstep, vol);
  endtask

  task automatic test_random_traffic(input int unsigned gap, input int unsigned stall,
                                     input int unsigned n_items);
    int unsigned sent;
    int unsigned burst;
    logic        f;
    gap_pct = gap;
    stall_pct = stall;
    sent = 0;
    while (sent < n_items) begin
      wait_idle();
      randomize_voice();
      burst = $urandom_range(30, 120);
      repeat (burst) begin
        if (tone_on) begin
          f = ($urandom_range(99) < 4);
        end else begin
          f = ($urandom_range(99) < 80);
        end
        if (f || tone_on) sent++;
        send_request(f, 31'($urandom()));
      end
    end
    wait_idle();
  endtask

  initial begin
    fill_sine_lut();
    cfg_note_len = htg_pkg::NOTE_LENGTH_RST;
    cfg_fade_start = htg_pkg::FADE_START_RST;
    cfg_fade_step = htg_pkg::FADE_STEP_RST;
    cfg_volume = htg_pkg::VOLUME_RST;
    tone_phase = '0;
    tone_step = '0;
    tone_count = '0;
    tone_env = UNITY_GAIN;
    tone_on = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_ticks();
    test_default_note();
    test_gain_extremes();
    test_wrapping_length();
    test_random_traffic(30, 55, 650);
    test_random_traffic(55, 30, 650);
    test_random_traffic(0, 0, 650);
    wait_idle();
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("harmonic_tone_generator_tb: PASS");
    end else begin
      $display("harmonic_tone_generator_tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
